// ===== hw/rtl/imu_complementary_attitude_defines.svh =====
// ----------------------------------------------------------------------------
// imu complementary attitude assertion macros
// short wrappers for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_ATTITUDE_DEFINES_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_DEFINES_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define IMUCA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("imuca same-cycle check failed");

// next-cycle implication, clocked on aclk, off while in reset
`define IMUCA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("imuca next-cycle check failed");

`endif

// ===== hw/rtl/imuca_pkg.sv =====
// ----------------------------------------------------------------------------
// imuca_pkg
// constants, register indexes and helper functions of the attitude estimator
// ----------------------------------------------------------------------------
package imuca_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_ITERS    = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    localparam int HALF_TURN = 180 << ANGLE_FRAC_BITS;
    localparam int ZW        = 27;   // cordic angle accumulator width
    localparam int ATAN_SH   = 24 - ANGLE_FRAC_BITS;
    localparam int ATAN_RND  = (ATAN_SH == 0) ? 0 : (1 << (ATAN_SH - 1));
    localparam int GYRO_SH   = 48 - ANGLE_FRAC_BITS;

    localparam logic signed [24:0] HT_25 = 25'(HALF_TURN);
    localparam logic signed [24:0] NHT_25 = -25'(HALF_TURN);
    localparam logic signed [65:0] HT_66 = 66'(HALF_TURN);
    localparam logic signed [ZW-1:0] HT_Z = ZW'(HALF_TURN);
    localparam logic [63:0] GYRO_RND = 64'(1) << (GYRO_SH - 1);

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GYRO_OFFSET_X = 3'd0,
        CFG_GYRO_OFFSET_Y = 3'd1,
        CFG_GYRO_OFFSET_Z = 3'd2,
        CFG_BLEND_WEIGHT  = 3'd3,
        CFG_RATE_SCALE    = 3'd4,
        CFG_ONE_G_COUNTS  = 3'd5
    } cfg_idx_t;

    localparam logic signed [15:0] RST_GYRO_OFFSET_X = 16'sd87;
    localparam logic signed [15:0] RST_GYRO_OFFSET_Y = 16'sd15;
    localparam logic signed [15:0] RST_GYRO_OFFSET_Z = 16'sd24;
    localparam logic [15:0]        RST_BLEND_WEIGHT  = 16'd64225;
    localparam logic [31:0]        RST_RATE_SCALE    = 32'd4297327;
    localparam logic [14:0]        RST_ONE_G_COUNTS  = 15'd8192;

    // arctangent of 2^-i in degrees, rescaled from q24 with rounding
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:  t = 32'd754974720;
            5'd1:  t = 32'd445687602;
            5'd2:  t = 32'd235489088;
            5'd3:  t = 32'd119537938;
            5'd4:  t = 32'd60000934;
            5'd5:  t = 32'd30029717;
            5'd6:  t = 32'd15018523;
            5'd7:  t = 32'd7509720;
            5'd8:  t = 32'd3754917;
            5'd9:  t = 32'd1877466;
            5'd10: t = 32'd938734;
            5'd11: t = 32'd469367;
            5'd12: t = 32'd234684;
            5'd13: t = 32'd117342;
            5'd14: t = 32'd58671;
            5'd15: t = 32'd29335;
            5'd16: t = 32'd14668;
            5'd17: t = 32'd7334;
            5'd18: t = 32'd3667;
            5'd19: t = 32'd1833;
            5'd20: t = 32'd917;
            5'd21: t = 32'd458;
            5'd22: t = 32'd229;
            5'd23: t = 32'd115;
            default: t = 32'd0;
        endcase
        atan_entry = ZW'((t + 32'(ATAN_RND)) >> ATAN_SH);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < -66'sh0_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic signed [24:0] clamp_ht(input logic signed [65:0] v);
        if (v > HT_66) begin
            clamp_ht = HT_25;
        end else if (v < -HT_66) begin
            clamp_ht = NHT_25;
        end else begin
            clamp_ht = v[24:0];
        end
    endfunction

endpackage

// ===== hw/rtl/imu_complementary_attitude.sv =====
// ----------------------------------------------------------------------------
// imu_complementary_attitude
// complementary-filter attitude estimator for one six-axis sample per beat
// ----------------------------------------------------------------------------
// One input beat carries three accelerometer and three gyro readings, the
// interval in microseconds and a seed flag; one result beat follows each.
// The block handles one sample at a time. A trusted sample runs the gyro
// integration, the squares, the square root, the cordic and the blend; an
// untrusted one skips the cordic and the blend, and a seed sample skips the
// gyro integration and the blend. All arithmetic goes through a single
// shift-and-add multiplier that retires one multiplier bit per cycle, a
// two-bits-per-cycle square root and a shared cordic vectoring stage (16
// iterations per arctangent). A new sample is taken once the previous result
// has been handed to the output register, so a result waiting on m_ready
// does not hold back the next sample's work; it only holds the hand-over.
// Configuration writes are always accepted and are meant to happen while the
// block is idle. Angles are degrees with 16 fraction bits.
// ----------------------------------------------------------------------------
`include "imu_complementary_attitude_defines.svh"

module imu_complementary_attitude (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_accel_x,
    input  logic signed [15:0]                  s_accel_y,
    input  logic signed [15:0]                  s_accel_z,
    input  logic signed [15:0]                  s_rate_x,
    input  logic signed [15:0]                  s_rate_y,
    input  logic signed [15:0]                  s_rate_z,
    input  logic [15:0]                         s_interval_us,
    input  logic                                s_seed,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_roll_angle,
    output logic signed [31:0]                  m_pitch_angle,
    output logic signed [24:0]                  m_yaw_angle,
    output logic signed [24:0]                  m_tilt_roll,
    output logic signed [24:0]                  m_tilt_pitch,
    output logic [15:0]                         m_accel_magnitude,
    output logic                                m_accel_trusted,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imuca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data
);
    import imuca_pkg::*;

    // sequencer, one-hot
    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,   // waiting for a sample beat
        S_GSET  = 17'h00002,   // load gyro axis into multiplier
        S_GMUL1 = 17'h00004,   // |rate| * interval
        S_GMUL2 = 17'h00008,   // (...) * rate_scale
        S_GACC  = 17'h00010,   // round and integrate into angle
        S_SQSET = 17'h00020,   // load accel axis for squaring
        S_SQ    = 17'h00040,   // accumulate square
        S_SQRT  = 17'h00080,   // digit-by-digit square root
        S_TRUST = 17'h00100,   // magnitude window
        S_CSET  = 17'h00200,   // cordic quadrant set-up
        S_CORD  = 17'h00400,   // cordic vectoring iterations
        S_BSET  = 17'h00800,   // blend, gyro angle term
        S_BMUL1 = 17'h01000,
        S_BMUL2 = 17'h02000,   // blend, tilt term
        S_BFIN  = 17'h04000,   // round and saturate blend
        S_FIN   = 17'h08000,   // seed load
        S_OUT   = 17'h10000    // hand over to output register
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [15:0] off_x_reg, off_x_next;
    logic signed [15:0] off_y_reg, off_y_next;
    logic signed [15:0] off_z_reg, off_z_next;
    logic [15:0]        weight_reg, weight_next;
    logic [31:0]        scale_reg, scale_next;
    logic [14:0]        one_g_reg, one_g_next;

    // filter state
    logic signed [31:0] roll_reg, roll_next;
    logic signed [31:0] pitch_reg, pitch_next;
    logic signed [24:0] yaw_reg, yaw_next;
    logic signed [24:0] troll_reg, troll_next;
    logic signed [24:0] tpitch_reg, tpitch_next;

    // captured sample
    logic signed [15:0] ax_reg, ax_next;
    logic signed [15:0] ay_reg, ay_next;
    logic signed [15:0] az_reg, az_next;
    logic signed [15:0] rx_reg, rx_next;
    logic signed [15:0] ry_reg, ry_next;
    logic signed [15:0] rz_reg, rz_next;
    logic [15:0]        dt_reg, dt_next;
    logic               seed_reg, seed_next;

    // sequencing
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;

    // shift-and-add multiplier
    logic [63:0] mul_a_reg, mul_a_next;
    logic [31:0] mul_b_reg, mul_b_next;
    logic [63:0] acc_reg, acc_next;
    logic        gneg_reg, gneg_next;

    // square root
    logic [31:0] sqv_reg, sqv_next;
    logic [31:0] sqr_reg, sqr_next;
    logic [30:0] sqbit_reg, sqbit_next;
    logic        trusted_reg, trusted_next;

    // cordic
    logic signed [33:0]   cx_reg, cx_next;
    logic signed [33:0]   cy_reg, cy_next;
    logic signed [ZW-1:0] cz_reg, cz_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] o_roll_reg, o_roll_next;
    logic signed [31:0] o_pitch_reg, o_pitch_next;
    logic signed [24:0] o_yaw_reg, o_yaw_next;
    logic signed [24:0] o_troll_reg, o_troll_next;
    logic signed [24:0] o_tpitch_reg, o_tpitch_next;
    logic [15:0]        o_mag_reg, o_mag_next;
    logic               o_trust_reg, o_trust_next;

    // combinational helpers
    logic [63:0]        acc_sum;
    logic signed [15:0] g_raw, g_off;
    logic signed [16:0] g_sum;
    logic [16:0]        g_abs;
    logic signed [15:0] a_sel;
    logic [15:0]        a_abs;
    logic [63:0]        g_rnd;
    logic signed [65:0] g_delta;
    logic signed [65:0] ang_sum;
    logic signed [65:0] yaw_sum;
    logic [32:0]        sq_trial;
    logic [18:0]        mag5;
    logic [18:0]        lim4;
    logic [18:0]        lim6;
    logic signed [15:0] cy_in, cx_in;
    logic signed [33:0] cxs, cys;
    logic signed [24:0] z_clamped;
    logic [63:0]        b_rnd;
    logic signed [63:0] b_shift;
    logic               accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // one multiplier bit per cycle
    assign acc_sum = acc_reg + (mul_b_reg[0] ? mul_a_reg : 64'd0);

    // gyro axis with offset, 17-bit sum
    always_comb begin
        case (axis_reg)
            2'd0: begin
                g_raw = rx_reg;
                g_off = off_x_reg;
            end
            2'd1: begin
                g_raw = ry_reg;
                g_off = off_y_reg;
            end
            default: begin
                g_raw = rz_reg;
                g_off = off_z_reg;
            end
        endcase
    end
    assign g_sum = {g_raw[15], g_raw} + {g_off[15], g_off};
    assign g_abs = g_sum[16] ? 17'(-g_sum) : 17'(g_sum);

    // accel axis for squaring
    always_comb begin
        case (axis_reg)
            2'd0:    a_sel = ax_reg;
            2'd1:    a_sel = ay_reg;
            default: a_sel = az_reg;
        endcase
    end
    assign a_abs = a_sel[15] ? 16'(-a_sel) : 16'(a_sel);

    // rounded increment, sign of the rate
    assign g_rnd   = (acc_reg + GYRO_RND) >> GYRO_SH;
    assign g_delta = gneg_reg ? -$signed({2'b00, g_rnd}) : $signed({2'b00, g_rnd});
    assign ang_sum = (axis_reg == 2'd0) ? ($signed({{34{roll_reg[31]}}, roll_reg}) + g_delta)
                                        : ($signed({{34{pitch_reg[31]}}, pitch_reg}) + g_delta);
    assign yaw_sum = $signed({{41{yaw_reg[24]}}, yaw_reg}) + g_delta;

    assign sq_trial = {1'b0, sqr_reg} + {2'b00, sqbit_reg};

    // trust window: 0.8 g < mag < 1.2 g, scaled by five
    assign mag5 = {1'b0, sqr_reg[15:0], 2'b00} + {3'b000, sqr_reg[15:0]};
    assign lim4 = {2'b00, one_g_reg, 2'b00};
    assign lim6 = {2'b00, one_g_reg, 2'b00} + {3'b000, one_g_reg, 1'b0};

    assign cy_in = (axis_reg == 2'd0) ? ay_reg : ax_reg;
    assign cx_in = az_reg;
    assign cxs   = cx_reg >>> cnt_reg[4:0];
    assign cys   = cy_reg >>> cnt_reg[4:0];
    assign z_clamped = (cz_reg > HT_Z) ? HT_25
                     : ((cz_reg < -HT_Z) ? NHT_25 : cz_reg[24:0]);

    assign b_rnd   = acc_reg + 64'd32768;
    assign b_shift = $signed(b_rnd) >>> 16;

    always_comb begin
        state_next    = state_reg;
        off_x_next    = off_x_reg;
        off_y_next    = off_y_reg;
        off_z_next    = off_z_reg;
        weight_next   = weight_reg;
        scale_next    = scale_reg;
        one_g_next    = one_g_reg;
        roll_next     = roll_reg;
        pitch_next    = pitch_reg;
        yaw_next      = yaw_reg;
        troll_next    = troll_reg;
        tpitch_next   = tpitch_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        az_next       = az_reg;
        rx_next       = rx_reg;
        ry_next       = ry_reg;
        rz_next       = rz_reg;
        dt_next       = dt_reg;
        seed_next     = seed_reg;
        cnt_next      = cnt_reg;
        axis_next     = axis_reg;
        mul_a_next    = mul_a_reg;
        mul_b_next    = mul_b_reg;
        acc_next      = acc_reg;
        gneg_next     = gneg_reg;
        sqv_next      = sqv_reg;
        sqr_next      = sqr_reg;
        sqbit_next    = sqbit_reg;
        trusted_next  = trusted_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        o_roll_next   = o_roll_reg;
        o_pitch_next  = o_pitch_reg;
        o_yaw_next    = o_yaw_reg;
        o_troll_next  = o_troll_reg;
        o_tpitch_next = o_tpitch_reg;
        o_mag_next    = o_mag_reg;
        o_trust_next  = o_trust_reg;
        m_valid_next  = m_valid_reg;

        // output beat taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // register writes, indexes beyond the list are dropped
        if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_GYRO_OFFSET_X: off_x_next  = cfg_data[15:0];
                CFG_GYRO_OFFSET_Y: off_y_next  = cfg_data[15:0];
                CFG_GYRO_OFFSET_Z: off_z_next  = cfg_data[15:0];
                CFG_BLEND_WEIGHT:  weight_next = cfg_data[15:0];
                CFG_RATE_SCALE:    scale_next  = cfg_data;
                CFG_ONE_G_COUNTS:  one_g_next  = cfg_data[14:0];
                default: ;
            endcase
        end

        // shared multiplier step, overridden below where a phase ends
        if (state_reg == S_GMUL1 || state_reg == S_GMUL2 || state_reg == S_SQ ||
            state_reg == S_BMUL1 || state_reg == S_BMUL2) begin
            acc_next   = acc_sum;
            mul_a_next = mul_a_reg << 1;
            mul_b_next = mul_b_reg >> 1;
            cnt_next   = cnt_reg - 6'd1;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ax_next   = s_accel_x;
                    ay_next   = s_accel_y;
                    az_next   = s_accel_z;
                    rx_next   = s_rate_x;
                    ry_next   = s_rate_y;
                    rz_next   = s_rate_z;
                    dt_next   = s_interval_us;
                    seed_next = s_seed;
                    axis_next = 2'd0;
                    acc_next  = 64'd0;
                    if (s_seed) begin
                        troll_next  = '0;
                        tpitch_next = '0;
                        state_next  = S_SQSET;
                    end else begin
                        state_next = S_GSET;
                    end
                end
            end
            S_GSET: begin
                mul_a_next = {47'd0, g_abs};
                mul_b_next = {16'd0, dt_reg};
                acc_next   = 64'd0;
                cnt_next   = 6'd16;
                gneg_next  = g_sum[16];
                state_next = S_GMUL1;
            end
            S_GMUL1: begin
                if (cnt_reg == 6'd1) begin
                    mul_a_next = acc_sum;
                    mul_b_next = scale_reg;
                    acc_next   = 64'd0;
                    cnt_next   = 6'd32;
                    state_next = S_GMUL2;
                end
            end
            S_GMUL2: begin
                if (cnt_reg == 6'd1) begin
                    state_next = S_GACC;
                end
            end
            S_GACC: begin
                case (axis_reg)
                    2'd0: roll_next  = sat32(ang_sum);
                    2'd1: pitch_next = sat32(ang_sum);
                    default: begin
                        // wrap once into a half turn, then clamp
                        if (yaw_sum < -HT_66) begin
                            yaw_next = clamp_ht(yaw_sum + (HT_66 <<< 1));
                        end else if (yaw_sum > HT_66) begin
                            yaw_next = clamp_ht(yaw_sum - (HT_66 <<< 1));
                        end else begin
                            yaw_next = clamp_ht(yaw_sum);
                        end
                    end
                endcase
                if (axis_reg == 2'd2) begin
                    axis_next  = 2'd0;
                    acc_next   = 64'd0;
                    state_next = S_SQSET;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_GSET;
                end
            end
            S_SQSET: begin
                mul_a_next = {48'd0, a_abs};
                mul_b_next = {16'd0, a_abs};
                cnt_next   = 6'd16;
                state_next = S_SQ;
            end
            S_SQ: begin
                if (cnt_reg == 6'd1) begin
                    if (axis_reg == 2'd2) begin
                        sqv_next   = acc_sum[31:0];
                        sqr_next   = 32'd0;
                        sqbit_next = 31'h4000_0000;
                        cnt_next   = 6'd16;
                        state_next = S_SQRT;
                    end else begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SQSET;
                    end
                end
            end
            S_SQRT: begin
                if ({1'b0, sqv_reg} >= sq_trial) begin
                    sqv_next = sqv_reg - sq_trial[31:0];
                    sqr_next = (sqr_reg >> 1) + {1'b0, sqbit_reg};
                end else begin
                    sqr_next = sqr_reg >> 1;
                end
                sqbit_next = sqbit_reg >> 2;
                cnt_next   = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = S_TRUST;
                end
            end
            S_TRUST: begin
                trusted_next = (mag5 > lim4) && (mag5 < lim6);
                axis_next    = 2'd0;
                if ((mag5 > lim4) && (mag5 < lim6)) begin
                    state_next = S_CSET;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CSET: begin
                cnt_next = 6'd0;
                if (cy_in == 16'sd0) begin
                    // on the x axis: no iterations
                    cz_next  = cx_in[15] ? HT_Z : '0;
                    cnt_next = 6'(CORDIC_ITERS);
                end else if (cx_in[15]) begin
                    // left half plane: rotate by a half turn
                    cz_next = cy_in[15] ? -HT_Z : HT_Z;
                    cx_next = -($signed({{18{cx_in[15]}}, cx_in}) <<< 14);
                    cy_next = -($signed({{18{cy_in[15]}}, cy_in}) <<< 14);
                end else begin
                    cz_next = '0;
                    cx_next = $signed({{18{cx_in[15]}}, cx_in}) <<< 14;
                    cy_next = $signed({{18{cy_in[15]}}, cy_in}) <<< 14;
                end
                state_next = S_CORD;
            end
            S_CORD: begin
                if (cnt_reg == 6'(CORDIC_ITERS)) begin
                    if (axis_reg == 2'd0) begin
                        troll_next = z_clamped;
                        axis_next  = 2'd1;
                        state_next = S_CSET;
                    end else begin
                        tpitch_next = -z_clamped;
                        axis_next   = 2'd0;
                        state_next  = seed_reg ? S_FIN : S_BSET;
                    end
                end else begin
                    if (!cy_reg[33]) begin
                        cx_next = cx_reg + cys;
                        cy_next = cy_reg - cxs;
                        cz_next = cz_reg + atan_entry(cnt_reg[4:0]);
                    end else begin
                        cx_next = cx_reg - cys;
                        cy_next = cy_reg + cxs;
                        cz_next = cz_reg - atan_entry(cnt_reg[4:0]);
                    end
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_BSET: begin
                if (axis_reg == 2'd0) begin
                    mul_a_next = {{32{roll_reg[31]}}, roll_reg};
                end else begin
                    mul_a_next = {{32{pitch_reg[31]}}, pitch_reg};
                end
                mul_b_next = {16'd0, weight_reg};
                acc_next   = 64'd0;
                cnt_next   = 6'd16;
                state_next = S_BMUL1;
            end
            S_BMUL1: begin
                if (cnt_reg == 6'd1) begin
                    if (axis_reg == 2'd0) begin
                        mul_a_next = {{39{troll_reg[24]}}, troll_reg};
                    end else begin
                        mul_a_next = {{39{tpitch_reg[24]}}, tpitch_reg};
                    end
                    mul_b_next = {15'd0, 17'h10000 - {1'b0, weight_reg}};
                    cnt_next   = 6'd17;
                    state_next = S_BMUL2;
                end
            end
            S_BMUL2: begin
                if (cnt_reg == 6'd1) begin
                    state_next = S_BFIN;
                end
            end
            S_BFIN: begin
                if (axis_reg == 2'd0) begin
                    roll_next  = sat32($signed({{2{b_shift[63]}}, b_shift}));
                    axis_next  = 2'd1;
                    state_next = S_BSET;
                end else begin
                    pitch_next = sat32($signed({{2{b_shift[63]}}, b_shift}));
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (seed_reg) begin
                    roll_next  = {{7{troll_reg[24]}}, troll_reg};
                    pitch_next = {{7{tpitch_reg[24]}}, tpitch_reg};
                    yaw_next   = '0;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    o_roll_next   = roll_reg;
                    o_pitch_next  = pitch_reg;
                    o_yaw_next    = yaw_reg;
                    o_troll_next  = troll_reg;
                    o_tpitch_next = tpitch_reg;
                    o_mag_next    = sqr_reg[15:0];
                    o_trust_next  = trusted_reg;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            off_x_reg   <= RST_GYRO_OFFSET_X;
            off_y_reg   <= RST_GYRO_OFFSET_Y;
            off_z_reg   <= RST_GYRO_OFFSET_Z;
            weight_reg  <= RST_BLEND_WEIGHT;
            scale_reg   <= RST_RATE_SCALE;
            one_g_reg   <= RST_ONE_G_COUNTS;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            troll_reg   <= '0;
            tpitch_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            off_x_reg   <= off_x_next;
            off_y_reg   <= off_y_next;
            off_z_reg   <= off_z_next;
            weight_reg  <= weight_next;
            scale_reg   <= scale_next;
            one_g_reg   <= one_g_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
            troll_reg   <= troll_next;
            tpitch_reg  <= tpitch_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        az_reg       <= az_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        rz_reg       <= rz_next;
        dt_reg       <= dt_next;
        seed_reg     <= seed_next;
        cnt_reg      <= cnt_next;
        axis_reg     <= axis_next;
        mul_a_reg    <= mul_a_next;
        mul_b_reg    <= mul_b_next;
        acc_reg      <= acc_next;
        gneg_reg     <= gneg_next;
        sqv_reg      <= sqv_next;
        sqr_reg      <= sqr_next;
        sqbit_reg    <= sqbit_next;
        trusted_reg  <= trusted_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        o_roll_reg   <= o_roll_next;
        o_pitch_reg  <= o_pitch_next;
        o_yaw_reg    <= o_yaw_next;
        o_troll_reg  <= o_troll_next;
        o_tpitch_reg <= o_tpitch_next;
        o_mag_reg    <= o_mag_next;
        o_trust_reg  <= o_trust_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_roll_angle      = o_roll_reg;
    assign m_pitch_angle     = o_pitch_reg;
    assign m_yaw_angle       = o_yaw_reg;
    assign m_tilt_roll       = o_troll_reg;
    assign m_tilt_pitch      = o_tpitch_reg;
    assign m_accel_magnitude = o_mag_reg;
    assign m_accel_trusted   = o_trust_reg;

    // a sample beat always starts a busy period
    `IMUCA_ASSERT_NXT(a_busy_after_beat, s_valid && s_ready, !s_ready)
    // wrapped yaw stays within a half turn
    `IMUCA_ASSERT_IMP(a_yaw_range, m_valid, (m_yaw_angle <= HT_25) && (m_yaw_angle >= NHT_25))
    // tilt pitch stays within a half turn
    `IMUCA_ASSERT_IMP(a_tilt_range, m_valid, (m_tilt_pitch <= HT_25) && (m_tilt_pitch >= NHT_25))

endmodule
